// File: rtl/core/periodic_task_tick_scheduler_top_defines.svh
// assertion macros for the periodic task tick scheduler
// no dependencies; included by the files that hold assertions
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define PTTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ptts assertion failed");

// expression must never be true out of reset
`define PTTS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("ptts forbidden condition seen");

`else

`define PTTS_ASSERT(lbl, clk, rstn, prop)
`define PTTS_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: rtl/core/ptts_pkg.sv
// shared types and constants for the periodic task tick scheduler
// no dependencies; used by ptts_cell and periodic_task_tick_scheduler_top
package ptts_pkg;

    // default number of task slots
    localparam int TASK_SLOTS_DEF = 8;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int TIDX_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int DELAY_W  = 32;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_RESUME  = 3'd2,
        CMD_SUSPEND = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    // slot status codes
    typedef enum logic [1:0] {
        ST_INACTIVE  = 2'd0,
        ST_RUNNING   = 2'd1,
        ST_SUSPENDED = 2'd2
    } t_status;

    // decoded slot command broadcast to the cell row
    typedef struct packed {
        logic do_create;
        logic do_delete;
        logic do_resume;
        logic do_suspend;
    } t_cell_cmd;

endpackage

// File: rtl/core/periodic_task_tick_scheduler_top.sv
// slot commands are accepted whenever busy is low
// a tick walks a token down the row of slot cells, one slot per cycle, with busy
// high through the scan and a final flush step; results leave one per cycle as slots
// fire, one held back, and the last, marked o_last, is strobed once busy is low again
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset clears every slot to inactive, zero delay and period
`include "periodic_task_tick_scheduler_top_defines.svh"

module periodic_task_tick_scheduler_top #(
    parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptts_pkg::CMD_W-1:0]    i_command,
    input  logic [ptts_pkg::TIDX_W-1:0]   i_task_index,
    input  logic [ptts_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptts_pkg::DELAY_W-1:0]  i_first_delay,
    output logic                          o_strobe,
    output logic [ptts_pkg::TIDX_W-1:0]   o_fired_index,
    output logic                          o_fired,
    output logic                          o_last
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    logic                         w_accept;
    logic                         w_tick;
    ptts_pkg::t_cell_cmd          w_cmd;
    logic [TASK_SLOTS-1:0]        w_sel;
    logic [TASK_SLOTS-1:0]        w_fire;
    logic [TASK_SLOTS-1:0]        w_tok;
    logic                         w_any_fire;

    logic                         r_scan;
    logic                         n_scan;
    logic                         r_flush;
    logic                         n_flush;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             n_idx;
    logic                         r_pend_vld;
    logic                         n_pend_vld;
    logic [ptts_pkg::TIDX_W-1:0]  r_pend_idx;
    logic [ptts_pkg::TIDX_W-1:0]  n_pend_idx;
    logic                         r_out_vld;
    logic                         n_out_vld;
    logic [ptts_pkg::TIDX_W-1:0]  r_out_idx;
    logic [ptts_pkg::TIDX_W-1:0]  n_out_idx;
    logic                         r_out_fired;
    logic                         n_out_fired;
    logic                         r_out_last;
    logic                         n_out_last;

    assign busy     = r_scan || r_flush;
    assign w_accept = start && !busy;

    // command decode
    always_comb begin
        w_cmd  = '0;
        w_tick = 1'b0;
        unique case (ptts_pkg::t_cmd'(i_command))
            ptts_pkg::CMD_CREATE:  w_cmd.do_create  = w_accept;
            ptts_pkg::CMD_DELETE:  w_cmd.do_delete  = w_accept;
            ptts_pkg::CMD_RESUME:  w_cmd.do_resume  = w_accept;
            ptts_pkg::CMD_SUSPEND: w_cmd.do_suspend = w_accept;
            ptts_pkg::CMD_TICK:    w_tick           = w_accept;
            default:               w_tick           = 1'b0;
        endcase
    end

    // row of slot cells, token handed cell to cell
    for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
        assign w_sel[k] = w_accept && !w_tick && (32'(i_task_index) == k);

        ptts_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_sel    (w_sel[k]),
            .i_cmd    (w_cmd),
            .i_period (i_period),
            .i_delay  (i_first_delay),
            .i_tok    ((k == 0) ? w_tick : w_tok[(k == 0) ? 0 : k-1]),
            .o_tok    (w_tok[k]),
            .o_fire   (w_fire[k])
        );
    end

    assign w_any_fire = |w_fire;

    // scan control and result sequencing; one firing is held back so the
    // final one can carry the last mark
    always_comb begin
        n_scan      = r_scan;
        n_flush     = 1'b0;
        n_idx       = r_idx;
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_out_vld   = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_fired = r_out_fired;
        n_out_last  = r_out_last;
        if (w_tick) begin
            n_scan     = 1'b1;
            n_idx      = '0;
            n_pend_vld = 1'b0;
        end else if (r_scan) begin
            if (w_any_fire) begin
                if (r_pend_vld) begin
                    n_out_vld   = 1'b1;
                    n_out_idx   = r_pend_idx;
                    n_out_fired = 1'b1;
                    n_out_last  = 1'b0;
                end
                n_pend_vld = 1'b1;
                n_pend_idx = ptts_pkg::TIDX_W'(r_idx);
            end
            if (r_idx == IDX_W'(TASK_SLOTS - 1)) begin
                n_scan  = 1'b0;
                n_flush = 1'b1;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end else if (r_flush) begin
            n_out_vld   = 1'b1;
            n_out_last  = 1'b1;
            n_out_fired = r_pend_vld;
            n_out_idx   = r_pend_vld ? r_pend_idx : '0;
            n_pend_vld  = 1'b0;
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= 1'b0;
            r_flush    <= 1'b0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_scan     <= n_scan;
            r_flush    <= n_flush;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_out_idx   <= n_out_idx;
        r_out_fired <= n_out_fired;
        r_out_last  <= n_out_last;
    end

    assign o_strobe      = r_out_vld;
    assign o_fired_index = r_out_idx;
    assign o_fired       = r_out_fired;
    assign o_last        = r_out_last;

    // checks
    `PTTS_NEVER(a_scan_and_flush, i_clk, i_rst_n, r_scan && r_flush)
    `PTTS_ASSERT(a_one_fire, i_clk, i_rst_n, $onehot0(w_fire))
    `PTTS_ASSERT(a_flush_single, i_clk, i_rst_n, r_flush |=> !r_flush)
    `PTTS_ASSERT(a_last_frees, i_clk, i_rst_n, (o_strobe && o_last) |-> !busy)
    `PTTS_ASSERT(a_beat_source, i_clk, i_rst_n,
                 o_strobe |-> $past(r_flush || (r_scan && w_any_fire)))

endmodule

// File: rtl/core/ptts_cell.sv
// one task slot of the scheduler row: delay, period, status and tick token
// depends on ptts_pkg
module ptts_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sel,
    input  ptts_pkg::t_cell_cmd           i_cmd,
    input  logic [ptts_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptts_pkg::DELAY_W-1:0]  i_delay,
    input  logic                          i_tok,
    output logic                          o_tok,
    output logic                          o_fire
);

    logic [ptts_pkg::DELAY_W-1:0]  r_delay;
    logic [ptts_pkg::DELAY_W-1:0]  n_delay;
    logic [ptts_pkg::PERIOD_W-1:0] r_period;
    logic [ptts_pkg::PERIOD_W-1:0] n_period;
    ptts_pkg::t_status             r_status;
    ptts_pkg::t_status             n_status;
    logic                          r_tok;
    logic                          w_running;

    assign w_running = (r_status == ptts_pkg::ST_RUNNING);

    // slot fires when the tick token is here and the countdown is spent
    assign o_fire = r_tok && w_running && (r_delay == '0);
    assign o_tok  = r_tok;

    // slot commands, else countdown while the token visits
    always_comb begin
        n_delay  = r_delay;
        n_period = r_period;
        n_status = r_status;
        if (i_sel) begin
            if (i_cmd.do_create) begin
                n_delay  = i_delay;
                n_period = i_period;
                n_status = ptts_pkg::ST_RUNNING;
            end else if (i_cmd.do_delete) begin
                n_status = ptts_pkg::ST_INACTIVE;
            end else if (i_cmd.do_resume && (r_status != ptts_pkg::ST_INACTIVE)) begin
                n_status = ptts_pkg::ST_RUNNING;
            end else if (i_cmd.do_suspend && (r_status != ptts_pkg::ST_INACTIVE)) begin
                n_status = ptts_pkg::ST_SUSPENDED;
            end
        end else if (r_tok && w_running) begin
            if (r_delay == '0) begin
                // reload wraps to all ones for a zero period
                n_delay = ptts_pkg::DELAY_W'(r_period) - ptts_pkg::DELAY_W'(1);
            end else begin
                n_delay = r_delay - ptts_pkg::DELAY_W'(1);
            end
        end
    end

    // slot state and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_period <= '0;
            r_status <= ptts_pkg::ST_INACTIVE;
            r_tok    <= 1'b0;
        end else begin
            r_delay  <= n_delay;
            r_period <= n_period;
            r_status <= n_status;
            r_tok    <= i_tok;
        end
    end

endmodule
